// ----- rtl/core/class_display_hysteresis_hold_top_macros.svh -----
// Assertion macros for the class display hysteresis block.
// Included by the top level; needs nothing else.
`ifndef CLASS_DISPLAY_HYSTERESIS_HOLD_TOP_MACROS_SVH
`define CLASS_DISPLAY_HYSTERESIS_HOLD_TOP_MACROS_SVH

// same-cycle implication
`define CHDH_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("chdh assertion failed");

// next-cycle implication
`define CHDH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("chdh assertion failed");

`endif

// ----- rtl/core/chdh_pkg.sv -----
// Types and constants for the class display hysteresis block.
// No dependencies.
`default_nettype none
package chdh_pkg;

  typedef enum logic [1:0] {
    MODE_LISTEN  = 2'd0,
    MODE_SOUND   = 2'd1,
    MODE_MAYBE   = 2'd2,
    MODE_SPECIES = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_ENTER   = 3'd0,
    REG_EXIT    = 3'd1,
    REG_HOLD    = 3'd2,
    REG_SOUND   = 3'd3,
    REG_NEG     = 3'd4,
    REG_MINWIN  = 3'd5
  } reg_idx_e;

  localparam logic signed [15:0] NO_CLASS = 16'sh FFFF;

  localparam logic [15:0] ENTER_RST  = 16'd45875;
  localparam logic [15:0] EXIT_RST   = 16'd32768;
  localparam logic [19:0] HOLD_RST   = 20'd3000;
  localparam logic [19:0] SOUND_RST  = 20'd1000;
  localparam logic [14:0] NEG_RST    = 15'd0;
  localparam logic [7:0]  MINWIN_RST = 8'd2;

  typedef struct packed {
    logic [15:0] enter_thr;
    logic [15:0] exit_thr;
    logic [19:0] hold_ms;
    logic [19:0] sound_hold_ms;
    logic [14:0] neg_class;
    logic [7:0]  min_windows;
  } cfg_t;

  typedef struct packed {
    mode_e              mode;
    logic signed [15:0] shown_class;
    logic [15:0]        shown_conf;
    logic [31:0]        entry_time;
    logic [31:0]        version;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/core/chdh_core.sv -----
// Display decision state, updated at the edge that accepts each item.
// Depends on chdh_pkg.
`default_nettype none
module chdh_core import chdh_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               acc_i,
  input  wire cfg_t               cfg_i,
  input  wire logic [31:0]        now_ms_i,
  input  wire logic               gate_open_i,
  input  wire logic               new_result_i,
  input  wire logic signed [15:0] class_index_i,
  input  wire logic [7:0]         merged_windows_i,
  input  wire logic [15:0]        probability_i,
  output res_t                    res_o
);

  mode_e              mode_q, mode_d;
  logic signed [15:0] class_q, class_d;
  logic [15:0]        conf_q, conf_d;
  logic [31:0]        gate_t_q, gate_t_d;
  logic               gate_seen_q, gate_seen_d;
  logic [31:0]        support_q, support_d;
  logic [31:0]        entry_q, entry_d;
  logic [31:0]        version_q, version_d;

  logic        showing, cand, above_enter, above_exit;
  logic        do_species, do_keep, do_maybe, did_show, changed;
  logic        clear, want_sound;
  logic [31:0] support_age, gate_age;
  mode_e       want_mode;
  logic [1:0]  v_inc;

  always_comb begin
    showing     = (mode_q == MODE_SPECIES) || (mode_q == MODE_MAYBE);
    cand        = new_result_i && !class_index_i[15] &&
                  (class_index_i[14:0] != cfg_i.neg_class) &&
                  (merged_windows_i >= cfg_i.min_windows);
    above_enter = probability_i >= cfg_i.enter_thr;
    above_exit  = probability_i >= cfg_i.exit_thr;
    do_species  = cand && above_enter;
    do_keep     = cand && !above_enter && above_exit && showing &&
                  (class_index_i == class_q);
    do_maybe    = cand && !above_enter && above_exit && !showing;
    did_show    = do_species || do_keep || do_maybe;
    changed     = do_maybe || (do_species &&
                  ((mode_q != MODE_SPECIES) || (class_q != class_index_i)));

    support_age = now_ms_i - support_q;
    gate_age    = now_ms_i - gate_t_q;
    clear       = !did_show && showing && (support_age > {12'd0, cfg_i.hold_ms});
    want_sound  = gate_open_i ||
                  (gate_seen_q && (gate_age <= {12'd0, cfg_i.sound_hold_ms}));
    want_mode   = want_sound ? MODE_SOUND : MODE_LISTEN;

    mode_d      = mode_q;
    class_d     = class_q;
    conf_d      = conf_q;
    support_d   = support_q;
    entry_d     = entry_q;
    v_inc       = 2'd0;

    if (did_show) begin
      support_d = now_ms_i;
      conf_d    = probability_i;
      if (do_species) begin
        mode_d  = MODE_SPECIES;
        class_d = class_index_i;
      end else if (do_maybe) begin
        mode_d  = MODE_MAYBE;
        class_d = class_index_i;
      end
      if (changed) begin
        entry_d = now_ms_i;
        v_inc   = 2'd1;
      end
    end else if (clear) begin
      class_d = NO_CLASS;
      conf_d  = 16'd0;
      mode_d  = want_mode;
      v_inc   = want_sound ? 2'd2 : 2'd1;
    end else if (!showing) begin
      mode_d  = want_mode;
      v_inc   = (want_mode != mode_q) ? 2'd1 : 2'd0;
    end

    version_d   = version_q + {30'd0, v_inc};
    gate_seen_d = gate_seen_q || gate_open_i;
    gate_t_d    = gate_open_i ? now_ms_i : gate_t_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_LISTEN;
      class_q     <= NO_CLASS;
      conf_q      <= 16'd0;
      gate_t_q    <= 32'd0;
      gate_seen_q <= 1'b0;
      support_q   <= 32'd0;
      entry_q     <= 32'd0;
      version_q   <= 32'd0;
    end else if (acc_i) begin
      mode_q      <= mode_d;
      class_q     <= class_d;
      conf_q      <= conf_d;
      gate_t_q    <= gate_t_d;
      gate_seen_q <= gate_seen_d;
      support_q   <= support_d;
      entry_q     <= entry_d;
      version_q   <= version_d;
    end
  end

  always_comb begin
    res_o.mode        = mode_d;
    res_o.shown_class = class_d;
    res_o.shown_conf  = conf_d;
    res_o.entry_time  = entry_d;
    res_o.version     = version_d;
  end

endmodule
`default_nettype wire

// ----- rtl/core/class_display_hysteresis_hold_top.sv -----
// Top level of the class display hysteresis block: APB registers, decision
// core and a two-entry result buffer. Depends on chdh_pkg and chdh_core.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o | now_ms, gate, result fields
//   out     | output    | out_valid_o/out_ready_i | mode, class, confidence, times
//   apb     | input     | psel/penable, pready=1  | paddr, pwdata, prdata
//
// One item per cycle while the skid stage is empty; each accepted item's
// result is registered. The decision state updates at the accepting edge, so
// the next item may follow directly. A result register plus skid stage keep
// input ready for one more item while the output stalls. Reset is
// asynchronous and loads the register defaults; no clearing pass.
`default_nettype none
module class_display_hysteresis_hold_top import chdh_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [31:0]        now_ms_i,
  input  wire logic               gate_open_i,
  input  wire logic               new_result_i,
  input  wire logic signed [15:0] class_index_i,
  input  wire logic [7:0]         merged_windows_i,
  input  wire logic [15:0]        probability_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [1:0]         mode_o,
  output logic signed [15:0]      shown_class_o,
  output logic      [15:0]        shown_confidence_o,
  output logic      [31:0]        entry_time_ms_o,
  output logic      [31:0]        version_o
);

  cfg_t     cfg_q;
  reg_idx_e widx;
  logic     wr_en, acc;
  res_t     res, out_q, skid_q;
  logic     out_valid_q, skid_valid_q;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign widx   = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enter_thr     <= ENTER_RST;
      cfg_q.exit_thr      <= EXIT_RST;
      cfg_q.hold_ms       <= HOLD_RST;
      cfg_q.sound_hold_ms <= SOUND_RST;
      cfg_q.neg_class     <= NEG_RST;
      cfg_q.min_windows   <= MINWIN_RST;
    end else if (wr_en) begin
      unique case (widx)
        REG_ENTER:  cfg_q.enter_thr     <= pwdata[15:0];
        REG_EXIT:   cfg_q.exit_thr      <= pwdata[15:0];
        REG_HOLD:   cfg_q.hold_ms       <= pwdata[19:0];
        REG_SOUND:  cfg_q.sound_hold_ms <= pwdata[19:0];
        REG_NEG:    cfg_q.neg_class     <= pwdata[14:0];
        REG_MINWIN: cfg_q.min_windows   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_ENTER:  prdata = {16'd0, cfg_q.enter_thr};
      REG_EXIT:   prdata = {16'd0, cfg_q.exit_thr};
      REG_HOLD:   prdata = {12'd0, cfg_q.hold_ms};
      REG_SOUND:  prdata = {12'd0, cfg_q.sound_hold_ms};
      REG_NEG:    prdata = {17'd0, cfg_q.neg_class};
      REG_MINWIN: prdata = {24'd0, cfg_q.min_windows};
      default:    prdata = 32'd0;
    endcase
  end

  assign in_ready_o = !skid_valid_q;
  assign acc        = in_valid_i && in_ready_o;

  chdh_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .acc_i            (acc),
    .cfg_i            (cfg_q),
    .now_ms_i         (now_ms_i),
    .gate_open_i      (gate_open_i),
    .new_result_i     (new_result_i),
    .class_index_i    (class_index_i),
    .merged_windows_i (merged_windows_i),
    .probability_i    (probability_i),
    .res_o            (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && out_ready_i) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= acc;
      end
    end else if (!out_valid_q) begin
      out_valid_q  <= acc;
    end else if (acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && out_ready_i && skid_valid_q) begin
      out_q <= skid_q;
    end else if (acc && (!out_valid_q || out_ready_i)) begin
      out_q <= res;
    end
    if (acc && out_valid_q && !out_ready_i) begin
      skid_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign mode_o             = out_q.mode;
  assign shown_class_o      = out_q.shown_class;
  assign shown_confidence_o = out_q.shown_conf;
  assign entry_time_ms_o    = out_q.entry_time;
  assign version_o          = out_q.version;

`include "class_display_hysteresis_hold_top_macros.svh"

  `CHDH_ASSERT_NOW(a_skid_needs_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `CHDH_ASSERT_NEXT(a_stall_fills_skid, clk_i, rst_ni,
    acc && out_valid_q && !out_ready_i, skid_valid_q)
  `CHDH_ASSERT_NOW(a_class_matches_mode, clk_i, rst_ni, out_valid_q,
    (out_q.mode == MODE_SPECIES || out_q.mode == MODE_MAYBE) ==
    (out_q.shown_class != NO_CLASS))

endmodule
`default_nettype wire
